// ===== src/scicd_pkg.sv =====
// Package: beat types, command codes and the chain remap table for the input scan block.
`default_nettype none
package scicd_pkg;

  localparam int unsigned CHAIN_BITS  = 24;
  localparam int unsigned WORD_BITS   = 28;
  localparam int unsigned LED_BITS    = 9;
  localparam int unsigned LED_CHAIN   = 8;
  localparam int unsigned PIN_BITS    = 5;
  localparam int unsigned DIRECT_BITS = 3;
  localparam int unsigned Q_DEPTH     = 2;

  // Command codes on the input channel
  localparam logic [1:0] CMD_SCAN   = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Result kinds on the output channel
  localparam logic [1:0] KIND_SCAN  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_LEDS  = 2'd2;

  // Target input-word bit of each chain bit
  localparam logic [PIN_BITS-1:0] REMAP_POS [CHAIN_BITS] = '{
    5'd1,  5'd9,  5'd16, 5'd17,
    5'd2,  5'd10, 5'd18, 5'd19,
    5'd4,  5'd11, 5'd20, 5'd21,
    5'd5,  5'd12, 5'd22, 5'd23,
    5'd7,  5'd13, 5'd24, 5'd25,
    5'd8,  5'd14, 5'd26, 5'd27
  };

  // Target input-word bit of each direct button
  localparam logic [PIN_BITS-1:0] DIRECT_POS [DIRECT_BITS] = '{5'd0, 5'd3, 5'd6};

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,
    OP_REPORT = 2'd1,
    OP_SET    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [CHAIN_BITS-1:0]  chain_bits;
    logic [DIRECT_BITS-1:0] direct_bits;
    logic [LED_BITS-1:0]    led_mask;
    logic [LED_BITS-1:0]    led_value;
  } item_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [WORD_BITS-1:0] input_word;
    logic [LED_CHAIN-1:0] led_shift_word;
    logic [PIN_BITS-1:0]  changed_pin;
    logic                 pin_level;
    logic [LED_BITS-1:0]  led_readback;
    logic                 last;
  } result_t;

  // Decoded operation held in the queue between front and back
  typedef struct packed {
    op_t                  op;
    logic [WORD_BITS-1:0] word;
    logic [LED_BITS-1:0]  led_mask;
    logic [LED_BITS-1:0]  led_value;
  } op_entry_t;

endpackage
`default_nettype wire

// ===== src/scan_chain_input_change_detector_top.sv =====
// Top level: input scan chain change detector with LED control.
//
// Input channel (item_valid / item_stall / item) carries commands: scan,
// report changes, set LEDs under a mask, read LEDs. Output channel
// (result_valid / result_stall / result) returns scan results, change
// events and LED readbacks, each with a last flag for its command.
// A front end remaps scan bits and decodes the command into a two-entry
// queue; a back end executes one queued command at a time.
// A command beat is written into the queue; the back end then takes it from
// the queue head and loads its result beat into the output register.
// Scan, set and read are each executed at the queue head; a report walks one
// input bit per cycle up to the highest pending bit (at most 28), pausing
// while an event beat waits for the output register; a set, or a report with
// nothing pending, produces no beat. The report walk in the back end sets the rate.
// Reset clears the input word, the change mask, the LED bits, the queue and
// the output valid flag. When the receiver stalls, the held result stays put,
// scans, reads and report events wait, and once the queue fills item_stall rises.
`default_nettype none
module scan_chain_input_change_detector_top
  import scicd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  logic      q_full;
  logic      q_push;
  op_entry_t q_entry;
  logic      q_pop;
  logic      q_head_valid;
  op_entry_t q_head;

  scicd_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  scicd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  scicd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== src/scicd_front.sv =====
// Front end: accepts input beats, decodes the command and remaps scan bits.
`default_nettype none
module scicd_front
  import scicd_pkg::*;
(
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire item_t     item,
  input  wire logic      q_full,
  output logic           q_push,
  output op_entry_t      q_entry
);

  logic [WORD_BITS-1:0] word;

  // Handshake: take a beat whenever the queue has room
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  // Place chain and direct bits into the input word
  always_comb begin
    word = '0;
    for (int k = 0; k < CHAIN_BITS; k++) begin
      if (item.chain_bits[k]) begin
        word[REMAP_POS[k]] = 1'b1;
      end
    end
    for (int k = 0; k < DIRECT_BITS; k++) begin
      if (item.direct_bits[k]) begin
        word[DIRECT_POS[k]] = 1'b1;
      end
    end
  end

  // Classify the command
  always_comb begin
    q_entry           = '0;
    q_entry.led_mask  = item.led_mask;
    q_entry.led_value = item.led_value;
    unique case (item.command)
      CMD_SCAN: begin
        q_entry.op   = OP_SCAN;
        q_entry.word = word;
      end
      CMD_REPORT: q_entry.op = OP_REPORT;
      CMD_SET:    q_entry.op = OP_SET;
      CMD_READ:   q_entry.op = OP_READ;
      default:    q_entry.op = OP_READ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/scicd_queue.sv =====
// Short queue of decoded operations between front and back ends.
`default_nettype none
module scicd_queue
  import scicd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire op_entry_t push_entry,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output op_entry_t      head
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  op_entry_t          mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/scicd_back.sv =====
// Back end: holds input, change and LED state, walks reports, drives result beats.
`default_nettype none
module scicd_back
  import scicd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  wire op_entry_t head,
  output logic           pop,
  output logic           result_valid,
  input  wire logic      result_stall,
  output result_t        result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [WORD_BITS-1:0] current_inputs, current_inputs_next;
  logic [WORD_BITS-1:0] pending, pending_next;
  logic [LED_BITS-1:0]  led_bits, led_bits_next;
  logic [WORD_BITS-1:0] snap, snap_next;
  logic [PIN_BITS-1:0]  walk_idx, walk_idx_next;
  logic [WORD_BITS-1:0] snap_clr;
  logic                 out_free;
  logic                 out_load;
  result_t              out_beat;

  assign out_free = !result_valid || !result_stall;
  assign snap_clr = snap & ~(WORD_BITS'(1) << walk_idx);

  // Execute the head operation or one step of a report walk
  always_comb begin
    state_next          = state;
    current_inputs_next = current_inputs;
    pending_next        = pending;
    led_bits_next       = led_bits;
    snap_next           = snap;
    walk_idx_next       = walk_idx;
    pop                 = 1'b0;
    out_load            = 1'b0;
    out_beat            = '0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            OP_SCAN: begin
              if (out_free) begin
                pop                     = 1'b1;
                out_load                = 1'b1;
                current_inputs_next     = head.word;
                pending_next            = pending | (current_inputs ^ head.word);
                out_beat.result_kind    = KIND_SCAN;
                out_beat.input_word     = head.word;
                out_beat.led_shift_word = led_bits[LED_CHAIN:1];
                out_beat.last           = 1'b1;
              end
            end
            OP_REPORT: begin
              pop           = 1'b1;
              snap_next     = pending;
              pending_next  = '0;
              walk_idx_next = '0;
              if (pending != '0) begin
                state_next = ST_WALK;
              end
            end
            OP_SET: begin
              pop           = 1'b1;
              led_bits_next = (led_bits & ~head.led_mask) | (head.led_value & head.led_mask);
            end
            OP_READ: begin
              if (out_free) begin
                pop                   = 1'b1;
                out_load              = 1'b1;
                out_beat.result_kind  = KIND_LEDS;
                out_beat.led_readback = led_bits;
                out_beat.last         = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // one input bit per cycle, lowest first, holding while an event waits for the output
        if (snap[walk_idx]) begin
          if (out_free) begin
            out_load             = 1'b1;
            out_beat.result_kind = KIND_EVENT;
            out_beat.changed_pin = walk_idx;
            out_beat.pin_level   = current_inputs[walk_idx];
            out_beat.last        = (snap_clr == '0);
            snap_next            = snap_clr;
            walk_idx_next        = walk_idx + 1'b1;
            if (snap_clr == '0) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          walk_idx_next = walk_idx + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      current_inputs <= '0;
      pending        <= '0;
      led_bits       <= '0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      current_inputs <= current_inputs_next;
      pending        <= pending_next;
      led_bits       <= led_bits_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Walk registers and output payload
  always_ff @(posedge clk) begin
    snap     <= snap_next;
    walk_idx <= walk_idx_next;
    if (out_load) begin
      result <= out_beat;
    end
  end

endmodule
`default_nettype wire
